// ===== rtl/ucr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucr_pkg
// Types and constants for the serial command recogniser: characters,
// parser and process state codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package ucr_pkg;

  localparam int PREFIX_LEN = 5;

  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_BS   = 8'h08;

  localparam logic [15:0] FIRST_WAIT_RESET  = 16'd10;
  localparam logic [15:0] REPEAT_WAIT_RESET = 16'd3000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WAIT = 1'b1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [8:0] {
    PS_START = 9'b000000001,
    PS_R     = 9'b000000010,
    PS_S     = 9'b000000100,
    PS_T     = 9'b000001000,
    PS_O     = 9'b000010000,
    PS_K     = 9'b000100000,
    PS_END   = 9'b001000000,
    PS_BAD   = 9'b010000000,
    PS_IDLE  = 9'b100000000
  } parse_state_t;

  typedef enum logic [3:0] {
    QS_WAIT_RST  = 4'b0001,
    QS_ERROR     = 4'b0010,
    QS_SAMPLE    = 4'b0100,
    QS_AWAIT_ACK = 4'b1000
  } proc_state_t;

endpackage
`default_nettype wire

// ===== rtl/uart_command_recognizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_recognizer_core
// Recognises the typed commands !RST# and !OK# with backspace editing,
// echoes characters and drives the sample / report / timer request cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per handshake; in_tuser is the mode (0 = received
//            byte, 1 = process tick), in_tdata carries byte, sample, expiry.
//   out_*  : exactly one result item per input item, in order.
//   cfg_*  : register writes (index 0 first wait, 1 repeat wait), always
//            ready, to be used while the block is idle.
// Timing:
//   an accepted item is held in the input register, where the parser and
//   process machine update; the result is then registered in the result
//   register, which drives out_tvalid. One item per cycle is sustained
//   while out_tready stays high, since the state update is done in the
//   input register stage.
// Reset:
//   parser idle, process waiting for RST, typed count and held sample zero,
//   wait registers at 10 and 3000 ticks. The prefix store is not cleared.
// Stall:
//   while out_tready is low a pending result stays in the result register;
//   the input register fills, then in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module uart_command_recognizer_core #(
  parameter int BUFFER_DEPTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // rx_byte[7:0], adc_sample[19:8], timer_expired[20], zero fill
  input  wire  [ucr_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode[0]
  input  wire  [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // echo_valid[0], echo_byte[8:1], send_error[9], send_report[10],
  // report_value[22:11], report_newline_first[23], timer_load[24],
  // timer_ticks[40:25], led_toggle[41], zero fill
  output logic [ucr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [ucr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [15:0]                       cfg_data
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  logic [15:0] first_wait_r;
  logic [15:0] repeat_wait_r;

  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [7:0]  s1_byte_r;
  logic [11:0] s1_sample_r;
  logic        s1_exp_r;
  logic        s1_adv;

  ucr_pkg::parse_state_t parse_r, parse_nxt;
  ucr_pkg::proc_state_t  proc_r, proc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_dec;
  logic [11:0]      held_r, held_nxt;
  logic [7:0]       prefix_r [ucr_pkg::PREFIX_LEN];
  logic             push;

  logic                        out_valid_r;
  logic [ucr_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [ucr_pkg::OUT_DATA_W-1:0] res_nxt;

  logic        echo_valid, send_error, send_report, newline_first;
  logic        timer_load, led_toggle;
  logic [7:0]  echo_byte;
  logic [11:0] report_value;
  logic [15:0] timer_ticks;

  logic        m0, m1r, m1o, m2s, m2k, m3t, m3h, m4h, is_ok;
  logic [7:0]  want, want2;
  logic        want2_en;
  ucr_pkg::parse_state_t next_s, next2_s, prev_s;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_wait_r  <= ucr_pkg::FIRST_WAIT_RESET;
      repeat_wait_r <= ucr_pkg::REPEAT_WAIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ucr_pkg::CFG_FIRST_WAIT:  first_wait_r  <= cfg_data;
        ucr_pkg::CFG_REPEAT_WAIT: repeat_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r   <= in_tuser[0];
      s1_byte_r   <= in_tdata[7:0];
      s1_sample_r <= in_tdata[19:8];
      s1_exp_r    <= in_tdata[20];
    end
  end

  // prefix matches
  assign m0    = prefix_r[0] == ucr_pkg::CH_BANG;
  assign m1r   = prefix_r[1] == ucr_pkg::CH_R;
  assign m1o   = prefix_r[1] == ucr_pkg::CH_O;
  assign m2s   = prefix_r[2] == ucr_pkg::CH_S;
  assign m2k   = prefix_r[2] == ucr_pkg::CH_K;
  assign m3t   = prefix_r[3] == ucr_pkg::CH_T;
  assign m3h   = prefix_r[3] == ucr_pkg::CH_HASH;
  assign m4h   = prefix_r[4] == ucr_pkg::CH_HASH;
  assign is_ok = m1o;

  assign count_dec = (count_r != '0) ? count_r - CNT_W'(1) : count_r;

  // expected letters per command state
  always_comb begin
    want     = ucr_pkg::CH_HASH;
    want2    = ucr_pkg::CH_O;
    want2_en = 1'b0;
    next_s   = ucr_pkg::PS_BAD;
    next2_s  = ucr_pkg::PS_BAD;
    prev_s   = ucr_pkg::PS_IDLE;
    unique case (parse_r)
      ucr_pkg::PS_START: begin
        want = ucr_pkg::CH_R; next_s = ucr_pkg::PS_R;
        want2_en = 1'b1; next2_s = ucr_pkg::PS_O; prev_s = ucr_pkg::PS_IDLE;
      end
      ucr_pkg::PS_R: begin
        want = ucr_pkg::CH_S; next_s = ucr_pkg::PS_S; prev_s = ucr_pkg::PS_START;
      end
      ucr_pkg::PS_S: begin
        want = ucr_pkg::CH_T; next_s = ucr_pkg::PS_T; prev_s = ucr_pkg::PS_R;
      end
      ucr_pkg::PS_T: begin
        want = ucr_pkg::CH_HASH; next_s = ucr_pkg::PS_END; prev_s = ucr_pkg::PS_S;
      end
      ucr_pkg::PS_O: begin
        want = ucr_pkg::CH_K; next_s = ucr_pkg::PS_K; prev_s = ucr_pkg::PS_START;
      end
      ucr_pkg::PS_K: begin
        want = ucr_pkg::CH_HASH; next_s = ucr_pkg::PS_END; prev_s = ucr_pkg::PS_O;
      end
      default: ;
    endcase
  end

  // parser and process update
  always_comb begin
    parse_nxt     = parse_r;
    proc_nxt      = proc_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    push          = 1'b0;
    echo_valid    = 1'b0;
    echo_byte     = 8'd0;
    send_error    = 1'b0;
    send_report   = 1'b0;
    report_value  = 12'd0;
    newline_first = 1'b0;
    timer_load    = 1'b0;
    timer_ticks   = 16'd0;
    led_toggle    = 1'b0;

    if (!s1_mode_r) begin
      if (count_r >= DEPTH_C) begin
        // buffer full
        send_error = 1'b1;
        parse_nxt  = ucr_pkg::PS_IDLE;
        count_nxt  = '0;
      end else if (parse_r == ucr_pkg::PS_IDLE) begin
        if (s1_byte_r != ucr_pkg::CH_CR && s1_byte_r != ucr_pkg::CH_BS) begin
          echo_valid = 1'b1;
          echo_byte  = s1_byte_r;
          parse_nxt  = (s1_byte_r == ucr_pkg::CH_BANG) ? ucr_pkg::PS_START
                                                       : ucr_pkg::PS_BAD;
          push       = 1'b1;
        end
      end else begin
        echo_valid = 1'b1;
        echo_byte  = s1_byte_r;
        if (parse_r == ucr_pkg::PS_BAD) begin
          if (s1_byte_r == ucr_pkg::CH_CR) begin
            parse_nxt = ucr_pkg::PS_IDLE;
            count_nxt = '0;
            proc_nxt  = ucr_pkg::QS_ERROR;
          end else if (s1_byte_r != ucr_pkg::CH_BS) begin
            push = 1'b1;
          end else begin
            count_nxt = count_dec;
            // re-enter a command state when the line is a valid prefix again, idle when empty
            if (count_dec == CNT_W'(5) && m0 && m1r && m2s && m3t && m4h)
              parse_nxt = ucr_pkg::PS_END;
            else if (count_dec == CNT_W'(2) && m0 && m1r)
              parse_nxt = ucr_pkg::PS_R;
            else if (count_dec == CNT_W'(3) && m0 && m1r && m2s)
              parse_nxt = ucr_pkg::PS_S;
            else if (count_dec == CNT_W'(4) && m0 && m1r && m2s && m3t)
              parse_nxt = ucr_pkg::PS_T;
            if (count_dec == CNT_W'(4) && m0 && m1o && m2k && m3h)
              parse_nxt = ucr_pkg::PS_END;
            else if (count_dec == CNT_W'(3) && m0 && m1o && m2k)
              parse_nxt = ucr_pkg::PS_K;
            else if (count_dec == CNT_W'(2) && m0 && m1o)
              parse_nxt = ucr_pkg::PS_O;
            else if (count_dec == CNT_W'(1) && m0)
              parse_nxt = ucr_pkg::PS_START;
            else if (count_dec == '0)
              parse_nxt = ucr_pkg::PS_IDLE;
          end
        end else if (parse_r == ucr_pkg::PS_END) begin
          if (s1_byte_r == ucr_pkg::CH_CR) begin
            parse_nxt = ucr_pkg::PS_IDLE;
            count_nxt = '0;
            if (is_ok) begin
              if (held_r != 12'd0) begin
                proc_nxt = ucr_pkg::QS_WAIT_RST;
                held_nxt = 12'd0;
              end else begin
                proc_nxt = ucr_pkg::QS_ERROR;
              end
            end else begin
              proc_nxt = ucr_pkg::QS_SAMPLE;
            end
          end else if (s1_byte_r == ucr_pkg::CH_BS) begin
            parse_nxt = is_ok ? ucr_pkg::PS_K : ucr_pkg::PS_T;
            count_nxt = count_dec;
          end else begin
            parse_nxt = ucr_pkg::PS_BAD;
            push      = 1'b1;
          end
        end else begin
          if (s1_byte_r == want) begin
            parse_nxt = next_s;
            push      = 1'b1;
          end else if (want2_en && s1_byte_r == want2) begin
            parse_nxt = next2_s;
            push      = 1'b1;
          end else if (s1_byte_r == ucr_pkg::CH_BS) begin
            parse_nxt = prev_s;
            count_nxt = count_dec;
          end else if (s1_byte_r == ucr_pkg::CH_CR) begin
            parse_nxt = ucr_pkg::PS_IDLE;
            count_nxt = '0;
            proc_nxt  = ucr_pkg::QS_ERROR;
          end else begin
            parse_nxt = ucr_pkg::PS_BAD;
            push      = 1'b1;
          end
        end
      end
      if (push) count_nxt = count_r + CNT_W'(1);
    end else begin
      unique case (proc_r)
        ucr_pkg::QS_SAMPLE: begin
          held_nxt    = s1_sample_r;
          proc_nxt    = ucr_pkg::QS_AWAIT_ACK;
          timer_load  = 1'b1;
          timer_ticks = first_wait_r;
        end
        ucr_pkg::QS_AWAIT_ACK: begin
          if (s1_exp_r) begin
            send_report   = 1'b1;
            report_value  = held_r;
            newline_first = count_r != '0;
            led_toggle    = 1'b1;
            count_nxt     = '0;
            parse_nxt     = ucr_pkg::PS_IDLE;
            timer_load    = 1'b1;
            timer_ticks   = repeat_wait_r;
          end
        end
        ucr_pkg::QS_ERROR: begin
          proc_nxt   = (held_r == 12'd0) ? ucr_pkg::QS_WAIT_RST
                                         : ucr_pkg::QS_AWAIT_ACK;
          send_error = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res_nxt = {6'd0, led_toggle, timer_ticks, timer_load, newline_first,
                    report_value, send_report, send_error, echo_byte, echo_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_r <= ucr_pkg::PS_IDLE;
      proc_r  <= ucr_pkg::QS_WAIT_RST;
      count_r <= '0;
      held_r  <= 12'd0;
    end else if (s1_adv) begin
      parse_r <= parse_nxt;
      proc_r  <= proc_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
    end
  end

  // first characters of the line
  for (genvar i = 0; i < ucr_pkg::PREFIX_LEN; i++) begin : g_prefix
    always_ff @(posedge clk) begin
      if (s1_adv && push && count_r == CNT_W'(i)) begin
        prefix_r[i] <= s1_byte_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("typed count beyond buffer depth");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("processed item produced no result");

  a_report_on_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_mode_r && s1_exp_r && proc_r == ucr_pkg::QS_AWAIT_ACK)
    |=> (out_tdata_r[10] && out_tdata_r[24] && out_tdata_r[41]))
    else $error("timer expiry while awaiting acknowledgement gave no report");
`endif

endmodule
`default_nettype wire
